// File: design/sha1he_pkg.sv
// SHA-1 hash engine: shared types, constants and helper functions.
// No dependencies; used by every other design file except sha1he_if.
`default_nettype none

package sha1he_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 61;
  localparam int unsigned RndW   = 7;
  localparam int unsigned MsgAw  = 4;
  localparam int unsigned ChainAw = 3;
  localparam int unsigned ChainDepth = 5;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  // Control for the round datapath.
  typedef struct packed {
    logic            load;   // shift a chain word into a, rest move down
    logic            shift;  // move b..e up into a..d for add-back
    logic            step;   // run one compression round
    logic [RndW-1:0] rnd;    // round index 0..79
  } rnd_ctrl_t;

  function automatic logic [WordW-1:0] iv_word(input logic [ChainAw-1:0] idx);
    logic [WordW-1:0] w;
    case (idx)
      3'd0:    w = 32'h67452301;
      3'd1:    w = 32'hEFCDAB89;
      3'd2:    w = 32'h98BADCFE;
      3'd3:    w = 32'h10325476;
      default: w = 32'hC3D2E1F0;
    endcase
    return w;
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                            input int unsigned s);
    return (v << s) | (v >> (WordW - s));
  endfunction

endpackage

`default_nettype wire

// File: design/sha1he_if.sv
// SHA-1 hash engine: valid/ready channel interfaces for bytes in and digest words out.
// Depends on nothing.
`default_nettype none

interface sha1he_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_data;
  logic       is_last;
  modport source (output valid, data_byte, has_data, is_last, input ready);
  modport sink   (input valid, data_byte, has_data, is_last, output ready);
endinterface

interface sha1he_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        word_last;
  modport source (output valid, digest_word, word_last, input ready);
  modport sink   (input valid, digest_word, word_last, output ready);
endinterface

`default_nettype wire

// File: design/sha1he_msg_mem.sv
// SHA-1 hash engine: 16-word message block memory, one write and one registered read port.
// Read data is masked by the padding zero limit and the length words. Uses sha1he_pkg.
`default_nettype none

module sha1he_msg_mem (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [sha1he_pkg::MsgAw-1:0]        wr_addr_i,
  input  logic [sha1he_pkg::WordW-1:0]        wr_data_i,
  input  logic                                rd_en_i,
  input  logic [sha1he_pkg::MsgAw-1:0]        rd_addr_i,
  input  logic [sha1he_pkg::MsgAw:0]          zlim_i,
  input  logic                                len_en_i,
  input  logic [sha1he_pkg::WordW-1:0]        len_hi_i,
  input  logic [sha1he_pkg::WordW-1:0]        len_lo_i,
  output logic [sha1he_pkg::WordW-1:0]        rd_data_o
);

  logic [sha1he_pkg::WordW-1:0] mem [16];
  logic [sha1he_pkg::WordW-1:0] rdata_q;
  logic [sha1he_pkg::MsgAw-1:0] raddr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      raddr_q <= rd_addr_i;
    end
  end

  // Padding: words past the 0x80 word read as zero, last two carry the bit length.
  always_comb begin
    if (len_en_i && raddr_q == 4'd14) begin
      rd_data_o = len_hi_i;
    end else if (len_en_i && raddr_q == 4'd15) begin
      rd_data_o = len_lo_i;
    end else if ({1'b0, raddr_q} >= zlim_i) begin
      rd_data_o = '0;
    end else begin
      rd_data_o = rdata_q;
    end
  end

endmodule

`default_nettype wire

// File: design/sha1he_chain_mem.sv
// SHA-1 hash engine: 5-word chain value memory with registered read.
// Entries never written since reset read as the initial vector. Uses sha1he_pkg.
`default_nettype none

module sha1he_chain_mem (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [sha1he_pkg::ChainAw-1:0] wr_addr_i,
  input  logic [sha1he_pkg::WordW-1:0]   wr_data_i,
  input  logic                           rd_en_i,
  input  logic [sha1he_pkg::ChainAw-1:0] rd_addr_i,
  output logic [sha1he_pkg::WordW-1:0]   rd_data_o
);

  logic [sha1he_pkg::WordW-1:0]      mem [sha1he_pkg::ChainDepth];
  logic [sha1he_pkg::ChainDepth-1:0] vld_q;
  logic [sha1he_pkg::WordW-1:0]      rdata_q;
  logic [sha1he_pkg::ChainAw-1:0]    raddr_q;
  logic                              rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      raddr_q <= rd_addr_i;
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : sha1he_pkg::iv_word(raddr_q);

endmodule

`default_nettype wire

// File: design/sha1he_round.sv
// SHA-1 hash engine: working variables a..e, one round per cycle, rolling 16-word schedule.
// Uses sha1he_pkg for the round control struct and constants.
`default_nettype none

module sha1he_round (
  input  logic                          clk_i,
  input  sha1he_pkg::rnd_ctrl_t         ctrl_i,
  input  logic [sha1he_pkg::WordW-1:0]  load_word_i,
  input  logic [sha1he_pkg::WordW-1:0]  msg_word_i,
  output logic [sha1he_pkg::WordW-1:0]  a_o
);

  logic [sha1he_pkg::WordW-1:0] a_q, b_q, c_q, d_q, e_q;
  logic [sha1he_pkg::WordW-1:0] win_q [16];
  logic [sha1he_pkg::WordW-1:0] w, f, k, tmp;

  always_comb begin
    if (ctrl_i.rnd < 7'd16) begin
      w = msg_word_i;
    end else begin
      w = sha1he_pkg::rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
    end
    if (ctrl_i.rnd < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = sha1he_pkg::K0;
    end else if (ctrl_i.rnd < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = sha1he_pkg::K1;
    end else if (ctrl_i.rnd < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = sha1he_pkg::K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = sha1he_pkg::K3;
    end
    tmp = sha1he_pkg::rotl(a_q, 5) + f + e_q + k + w;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      a_q <= tmp;
      b_q <= a_q;
      c_q <= sha1he_pkg::rotl(b_q, 30);
      d_q <= c_q;
      e_q <= d_q;
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w;
    end else if (ctrl_i.load) begin
      a_q <= load_word_i;
      b_q <= a_q;
      c_q <= b_q;
      d_q <= c_q;
      e_q <= d_q;
    end else if (ctrl_i.shift) begin
      a_q <= b_q;
      b_q <= c_q;
      c_q <= d_q;
      d_q <= e_q;
    end
  end

  assign a_o = a_q;

endmodule

`default_nettype wire

// File: design/sha1_hash_engine.sv
// SHA-1 hash engine top level: byte packing, padding, control sequencer, digest output.
// Depends on sha1he_pkg, sha1he_if, sha1he_msg_mem, sha1he_chain_mem, sha1he_round.
// A byte is taken only while the block is idle and is written into the 16-word block
// memory; the 64th byte of a block starts a compression (load the chain value from its
// memory, 80 rounds at one per cycle, add it back), and no byte is taken until it ends.
// The last item adds a padding step and one or two compressions; the five digest
// words leave in order h0..h4, one per cycle when the sink is ready, and the block
// accepts the next item once the last word is in the output register.
`default_nettype none

module sha1_hash_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  sha1he_in_if.sink         in_ch_i,
  sha1he_out_if.source      out_ch_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_ADD   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [2:0]                        cnt_q, cnt_d;
  logic [sha1he_pkg::RndW-1:0]       rnd_q, rnd_d;
  logic [sha1he_pkg::MsgAw:0]        zlim_q, zlim_d;
  logic                              len_en_q, len_en_d;
  logic                              fin_q, fin_d;
  logic                              second_q, second_d;
  logic                              last_pend_q, last_pend_d;
  logic [sha1he_pkg::CountW-1:0]     count_q, count_d;
  logic [sha1he_pkg::WordW-1:0]      acc_q, acc_d;
  logic                              out_valid_q, out_valid_d;
  logic [sha1he_pkg::WordW-1:0]      out_word_q;
  logic                              out_last_q;

  logic                              accept, adv, out_load, out_last_d;
  logic [5:0]                        pos;
  logic [4:0]                        sh;
  logic [sha1he_pkg::WordW-1:0]      byte_word, pad_word, sum;

  logic                              msg_wr_en, msg_rd_en;
  logic [sha1he_pkg::MsgAw-1:0]      msg_wr_addr, msg_rd_addr;
  logic [sha1he_pkg::WordW-1:0]      msg_wr_data, msg_rd_data;
  logic                              ch_wr_en, ch_rd_en;
  logic [sha1he_pkg::ChainAw-1:0]    ch_wr_addr, ch_rd_addr;
  logic [sha1he_pkg::WordW-1:0]      ch_wr_data, ch_rd_data;
  sha1he_pkg::rnd_ctrl_t             rctrl;
  logic [sha1he_pkg::WordW-1:0]      a_word;

  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign accept        = in_ch_i.valid && in_ch_i.ready;
  assign pos           = count_q[5:0];
  assign sh            = {~pos[1:0], 3'b000};
  assign byte_word     = acc_q | ({24'd0, in_ch_i.data_byte} << sh);
  assign pad_word      = acc_q | ({24'd0, sha1he_pkg::PadByte} << sh);
  assign sum           = ch_rd_data + a_word;
  // a digest word may only go out when the output register is free
  assign adv           = (cnt_q == 3'd0) || !fin_q || !out_valid_q || out_ch_o.ready;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rnd_d       = rnd_q;
    zlim_d      = zlim_q;
    len_en_d    = len_en_q;
    fin_d       = fin_q;
    second_d    = second_q;
    last_pend_d = last_pend_q;
    count_d     = count_q;
    acc_d       = acc_q;
    msg_wr_en   = 1'b0;
    msg_wr_addr = pos[5:2];
    msg_wr_data = byte_word;
    msg_rd_en   = 1'b0;
    msg_rd_addr = '0;
    ch_wr_en    = 1'b0;
    ch_wr_addr  = cnt_q - 3'd1;
    ch_wr_data  = sum;
    ch_rd_en    = 1'b0;
    ch_rd_addr  = cnt_q;
    rctrl       = '{load: 1'b0, shift: 1'b0, step: 1'b0, rnd: rnd_q};
    out_load    = 1'b0;
    out_last_d  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch_i.has_data) begin
            msg_wr_en = 1'b1;
            count_d   = count_q + 61'd1;
            acc_d     = (pos[1:0] == 2'd3) ? '0 : byte_word;
            if (pos == 6'd63) begin
              zlim_d      = 5'd16;
              len_en_d    = 1'b0;
              fin_d       = 1'b0;
              second_d    = 1'b0;
              last_pend_d = in_ch_i.is_last;
              cnt_d       = '0;
              state_d     = ST_LOAD;
            end else if (in_ch_i.is_last) begin
              state_d = ST_PAD;
            end
          end else if (in_ch_i.is_last) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        msg_wr_en   = 1'b1;
        msg_wr_data = pad_word;
        zlim_d      = {1'b0, pos[5:2]} + 5'd1;
        last_pend_d = 1'b0;
        cnt_d       = '0;
        state_d     = ST_LOAD;
        if (pos >= 6'd56) begin
          len_en_d = 1'b0;
          second_d = 1'b1;
          fin_d    = 1'b0;
        end else begin
          len_en_d = 1'b1;
          second_d = 1'b0;
          fin_d    = 1'b1;
        end
      end
      ST_LOAD: begin
        // chain words come in h4 first so that h0 ends in a
        ch_rd_en   = (cnt_q != 3'd5);
        ch_rd_addr = 3'd4 - cnt_q;
        rctrl.load = (cnt_q != 3'd0);
        if (cnt_q == 3'd5) begin
          msg_rd_en = 1'b1;
          rnd_d     = '0;
          state_d   = ST_ROUND;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_ROUND: begin
        rctrl.step  = 1'b1;
        msg_rd_en   = (rnd_q < 7'd15);
        msg_rd_addr = rnd_q[3:0] + 4'd1;
        if (rnd_q == 7'd79) begin
          cnt_d   = '0;
          state_d = ST_ADD;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      ST_ADD: begin
        if (adv) begin
          ch_rd_en = (cnt_q != 3'd5);
          if (cnt_q != 3'd0) begin
            ch_wr_en    = 1'b1;
            ch_wr_data  = fin_q ? sha1he_pkg::iv_word(cnt_q - 3'd1) : sum;
            rctrl.shift = 1'b1;
            out_load    = fin_q;
            out_last_d  = (cnt_q == 3'd5);
          end
          if (cnt_q == 3'd5) begin
            cnt_d = '0;
            if (second_q) begin
              zlim_d   = '0;
              len_en_d = 1'b1;
              fin_d    = 1'b1;
              second_d = 1'b0;
              state_d  = ST_LOAD;
            end else if (fin_q) begin
              fin_d   = 1'b0;
              count_d = '0;
              acc_d   = '0;
              state_d = ST_IDLE;
            end else if (last_pend_q) begin
              state_d = ST_PAD;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rnd_q       <= '0;
      zlim_q      <= '0;
      len_en_q    <= 1'b0;
      fin_q       <= 1'b0;
      second_q    <= 1'b0;
      last_pend_q <= 1'b0;
      count_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rnd_q       <= rnd_d;
      zlim_q      <= zlim_d;
      len_en_q    <= len_en_d;
      fin_q       <= fin_d;
      second_q    <= second_d;
      last_pend_q <= last_pend_d;
      count_q     <= count_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= sum;
      out_last_q <= out_last_d;
    end
  end

  assign out_ch_o.valid       = out_valid_q;
  assign out_ch_o.digest_word = out_word_q;
  assign out_ch_o.word_last   = out_last_q;

  sha1he_msg_mem u_msg_mem (
    .clk_i     (clk_i),
    .wr_en_i   (msg_wr_en),
    .wr_addr_i (msg_wr_addr),
    .wr_data_i (msg_wr_data),
    .rd_en_i   (msg_rd_en),
    .rd_addr_i (msg_rd_addr),
    .zlim_i    (zlim_q),
    .len_en_i  (len_en_q),
    .len_hi_i  (count_q[60:29]),
    .len_lo_i  ({count_q[28:0], 3'b000}),
    .rd_data_o (msg_rd_data)
  );

  sha1he_chain_mem u_chain_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ch_wr_en),
    .wr_addr_i (ch_wr_addr),
    .wr_data_i (ch_wr_data),
    .rd_en_i   (ch_rd_en),
    .rd_addr_i (ch_rd_addr),
    .rd_data_o (ch_rd_data)
  );

  sha1he_round u_round (
    .clk_i       (clk_i),
    .ctrl_i      (rctrl),
    .load_word_i (ch_rd_data),
    .msg_word_i  (msg_rd_data),
    .a_o         (a_word)
  );

`ifndef SYNTHESIS
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> rnd_q <= 7'd79)
    else $error("round index out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ch_o.ready))
    else $error("digest word overwrites a pending transfer");

  a_final_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && cnt_q == 3'd5 && fin_q && adv)
      |=> (count_q == '0 && state_q == ST_IDLE))
    else $error("byte count not cleared after digest");

  a_zlim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> zlim_q <= 5'd16)
    else $error("zero limit out of range");
`endif

endmodule

`default_nettype wire
